@@ hw/rtl/ps2mpt_pkg.sv @@
`default_nettype none
package ps2mpt_pkg;

   localparam int POS_BITS  = 12;
   localparam int CFG_BITS  = 12;
   localparam int BYTE_BITS = 8;
   localparam int WIDE_BITS = (CFG_BITS > POS_BITS) ? CFG_BITS + 1 : POS_BITS + 1;
   localparam int SUM_BITS  = POS_BITS + 2;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   localparam logic [CSR_IDX_BITS-1:0] CSR_AREA_WIDTH  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_AREA_HEIGHT = CSR_IDX_BITS'(1);

   localparam logic [CFG_BITS-1:0] AREA_WIDTH_RST  = CFG_BITS'(800);
   localparam logic [CFG_BITS-1:0] AREA_HEIGHT_RST = CFG_BITS'(400);

   localparam int HDR_SYNC_BIT  = 3;
   localparam int HDR_XSIGN_BIT = 4;
   localparam int HDR_YSIGN_BIT = 5;

   typedef enum logic [1:0] {
      SLOT_HDR = 2'd0,
      SLOT_DX  = 2'd1,
      SLOT_DY  = 2'd2
   } slot_type;

   typedef struct packed {
      logic                 neg;
      logic [BYTE_BITS-1:0] mag;
   } delta_type;

   function automatic logic [POS_BITS-1:0] sat_pos(input logic [CFG_BITS-1:0] v);
      logic [WIDE_BITS-1:0] wide_v;
      wide_v = WIDE_BITS'(v);
      if (wide_v > WIDE_BITS'(POS_MAX)) begin
         return POS_MAX;
      end
      return wide_v[POS_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ps2mpt_axis.sv @@
`default_nettype none
module ps2mpt_axis
   import ps2mpt_pkg::*;
(
   input  wire logic [POS_BITS-1:0] pos,
   input  wire delta_type           delta,
   input  wire logic [CFG_BITS-1:0] area,
   output logic      [POS_BITS-1:0] pos_next
);

   logic signed [SUM_BITS-1:0] sum;
   logic        [POS_BITS-1:0] lim;

   always_comb begin
      lim = sat_pos(area);
      sum = $signed(SUM_BITS'(pos)) + $signed(SUM_BITS'(delta.mag));
      if (delta.neg) begin
         sum = sum - $signed(SUM_BITS'(1 << BYTE_BITS));
      end
      if (sum[SUM_BITS-1]) begin
         pos_next = '0;
      end else if (sum[SUM_BITS-2:0] > (SUM_BITS-1)'(lim)) begin
         pos_next = lim;
      end else begin
         pos_next = sum[POS_BITS-1:0];
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/ps2_mouse_position_tracker_top.sv @@
`default_nettype none
// channel | ports                          | transfer when
// --------+--------------------------------+-----------------------
// request | req_valid req_ready req_rx_byte | req_valid & req_ready
// result  | rsp_valid rsp_ready rsp_pos_x/y | rsp_valid & rsp_ready
// config  | csr_we csr_index csr_wdata     | csr_we
//
// One byte per cycle unless the output stalls; a result is registered in the cycle
// after the third byte of a good packet. req_ready drops only while a result is
// held and rsp_ready is low. Reset is synchronous: slot to header, area 800 x 400,
// position 800,400. A result register parts the two sides; no other buffering.
module ps2_mouse_position_tracker_top
   import ps2mpt_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [BYTE_BITS-1:0]    req_rx_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [POS_BITS-1:0]     rsp_pos_x,
   output logic      [POS_BITS-1:0]     rsp_pos_y,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]     csr_wdata
);

   slot_type             slot_ff, slot_in;
   logic [BYTE_BITS-1:0] hdr_ff, hdr_in;
   logic [BYTE_BITS-1:0] dx_ff, dx_in;
   logic                 skip_ff, skip_in;
   logic [POS_BITS-1:0]  cur_x_ff, cur_x_in;
   logic [POS_BITS-1:0]  cur_y_ff, cur_y_in;
   logic [CFG_BITS-1:0]  area_w_ff, area_h_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]  rsp_x_ff, rsp_y_ff;
   logic                 accept, emit;
   delta_type            delta_x, delta_y;
   logic [POS_BITS-1:0]  new_x, new_y;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign delta_x = '{neg: hdr_ff[HDR_XSIGN_BIT], mag: dx_ff};
   assign delta_y = '{neg: hdr_ff[HDR_YSIGN_BIT], mag: req_rx_byte};

   ps2mpt_axis u_axis_x (
      .pos      (cur_x_ff),
      .delta    (delta_x),
      .area     (area_w_ff),
      .pos_next (new_x)
   );

   ps2mpt_axis u_axis_y (
      .pos      (cur_y_ff),
      .delta    (delta_y),
      .area     (area_h_ff),
      .pos_next (new_y)
   );

   always_comb begin
      slot_in  = slot_ff;
      hdr_in   = hdr_ff;
      dx_in    = dx_ff;
      skip_in  = skip_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      emit     = 1'b0;
      if (accept) begin
         if (skip_ff) begin
            // drop this byte to regain alignment
            skip_in = 1'b0;
            slot_in = SLOT_HDR;
         end else begin
            case (slot_ff)
               SLOT_DX: begin
                  dx_in   = req_rx_byte;
                  slot_in = SLOT_DY;
               end
               SLOT_DY: begin
                  slot_in = SLOT_HDR;
                  if (!hdr_ff[HDR_SYNC_BIT]) begin
                     skip_in = 1'b1;
                  end else begin
                     cur_x_in = new_x;
                     cur_y_in = new_y;
                     emit     = 1'b1;
                  end
               end
               default: begin
                  hdr_in  = req_rx_byte;
                  slot_in = SLOT_DX;
               end
            endcase
         end
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= SLOT_HDR;
         hdr_ff       <= '0;
         dx_ff        <= '0;
         skip_ff      <= 1'b0;
         cur_x_ff     <= sat_pos(AREA_WIDTH_RST);
         cur_y_ff     <= sat_pos(AREA_HEIGHT_RST);
         area_w_ff    <= AREA_WIDTH_RST;
         area_h_ff    <= AREA_HEIGHT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         hdr_ff       <= hdr_in;
         dx_ff        <= dx_in;
         skip_ff      <= skip_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_AREA_WIDTH) begin
            area_w_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_AREA_HEIGHT) begin
            area_h_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff <= new_x;
         rsp_y_ff <= new_y;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;

`ifndef ASSERT_OFF
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   a_skip_at_header: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> slot_ff == SLOT_HDR)
      else $error("skip pending outside header slot");

   a_result_from_packet: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept) && $past(slot_ff) == SLOT_DY && !$past(skip_ff))
      else $error("result without a completed packet");

   a_result_holds_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_x_ff == cur_x_ff && rsp_y_ff == cur_y_ff)
      else $error("held result differs from stored position");
`endif

endmodule
`default_nettype wire
